// File: hdl/utf8_to_latin1_transliterator_macros.svh
// Assertion macros for the UTF-8 to Latin-1 transliterator checker.
// Expects aclk and aresetn in the scope where the macros are used.
`ifndef UTF8_TO_LATIN1_TRANSLITERATOR_MACROS_SVH
`define UTF8_TO_LATIN1_TRANSLITERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define U2L_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define U2L_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/u2l_pkg.sv
// Shared types, constants and decode functions for the UTF-8 to Latin-1 transliterator.
// No dependencies.
package u2l_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned MAX_CHARS       = 4;
    localparam int unsigned CHAR_CNT_W      = $clog2(MAX_CHARS + 1);
    localparam int unsigned CHAR_IDX_W      = $clog2(MAX_CHARS);
    localparam int unsigned CP_W            = 21;

    localparam logic [15:0] OUT_LIMIT_RST = 16'd511;

    localparam logic [CP_W-1:0] CP_NBSP     = 21'h0000A0;
    localparam logic [CP_W-1:0] CP_SHY      = 21'h0000AD;
    localparam logic [CP_W-1:0] CP_LATIN1   = 21'h0000FF;
    localparam logic [CP_W-1:0] CP_SQ_LO    = 21'h002018;
    localparam logic [CP_W-1:0] CP_SQ_HI    = 21'h00201A;
    localparam logic [CP_W-1:0] CP_DQ_LO    = 21'h00201C;
    localparam logic [CP_W-1:0] CP_DQ_HI    = 21'h00201E;
    localparam logic [CP_W-1:0] CP_EN_DASH  = 21'h002013;
    localparam logic [CP_W-1:0] CP_EM_DASH  = 21'h002014;
    localparam logic [CP_W-1:0] CP_ELLIPSIS = 21'h002026;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;

    typedef enum logic [2:0] {
        NEED_NONE,
        NEED_ONE,
        NEED_TWO,
        NEED_THREE,
        NEED_RAW
    } need_t;

    // One decoded byte's worth of work: candidate characters and text end.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CHAR_CNT_W-1:0]     n;
        logic                      text_end;
    } job_t;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] ch;
    } map_t;

    function automatic need_t need_of(logic [7:0] b);
        need_t k;
        if (b[7] == 1'b0) begin
            k = NEED_NONE;
        end else if (b[7:5] == 3'b110) begin
            k = NEED_ONE;
        end else if (b[7:4] == 4'b1110) begin
            k = NEED_TWO;
        end else if (b[7:3] == 5'b11110) begin
            k = NEED_THREE;
        end else begin
            k = NEED_RAW;
        end
        return k;
    endfunction

    function automatic map_t map_cp(logic [CP_W-1:0] cp);
        map_t m;
        if (cp == CP_NBSP) begin
            m = '{n: 2'd1, ch: CH_SPACE};
        end else if (cp == CP_SHY) begin
            m = '{n: 2'd0, ch: 8'h00};
        end else if (cp <= CP_LATIN1) begin
            m = '{n: 2'd1, ch: cp[7:0]};
        end else if (cp inside {[CP_SQ_LO:CP_SQ_HI]}) begin
            m = '{n: 2'd1, ch: CH_APOS};
        end else if (cp inside {[CP_DQ_LO:CP_DQ_HI]}) begin
            m = '{n: 2'd1, ch: CH_QUOTE};
        end else if (cp == CP_EN_DASH || cp == CP_EM_DASH) begin
            m = '{n: 2'd1, ch: CH_HYPHEN};
        end else if (cp == CP_ELLIPSIS) begin
            m = '{n: 2'd3, ch: CH_DOT};
        end else begin
            m = '{n: 2'd1, ch: CH_QMARK};
        end
        return m;
    endfunction

endpackage

// File: hdl/u2l_front.sv
// Front end: accepts text bytes, tracks held UTF-8 bytes and builds character jobs.
// Depends on u2l_pkg.
module u2l_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     in_byte,
    input  logic           text_end,
    input  logic           q_full,
    output logic           q_push,
    output u2l_pkg::job_t  q_job
);
    import u2l_pkg::*;

    logic       lead_held_reg, lead_held_next;
    logic [7:0] held_lead_reg, held_lead_next;
    logic [1:0][7:0] cont_reg, cont_next;
    logic [1:0] held_count_reg, held_count_next;

    logic          accept;
    logic          take_lead;
    need_t         k_lead;
    need_t         k_byte;
    logic [CP_W-1:0] cp;
    map_t          map_seq;
    map_t          map_byte;
    job_t          job;

    function automatic job_t add_char(job_t j, logic [7:0] c);
        job_t r;
        r = j;
        if (r.n < CHAR_CNT_W'(MAX_CHARS)) begin
            r.chars[r.n[CHAR_IDX_W-1:0]] = c;
            r.n = r.n + CHAR_CNT_W'(1);
        end
        return r;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        k_lead = need_of(held_lead_reg);
        k_byte = need_of(in_byte);
        case (k_lead)
            NEED_ONE:   cp = {10'b0, held_lead_reg[4:0], in_byte[5:0]};
            NEED_TWO:   cp = {5'b0, held_lead_reg[3:0], cont_reg[0][5:0], in_byte[5:0]};
            NEED_THREE: cp = {held_lead_reg[2:0], cont_reg[0][5:0], cont_reg[1][5:0],
                              in_byte[5:0]};
            default:    cp = '0;
        endcase
        map_seq  = map_cp(cp);
        map_byte = map_cp({13'b0, in_byte});
    end

    always_comb begin
        job              = '0;
        job.text_end     = text_end;
        lead_held_next   = lead_held_reg;
        held_lead_next   = held_lead_reg;
        cont_next        = cont_reg;
        held_count_next  = held_count_reg;
        take_lead        = 1'b0;

        if (in_byte != 8'h00) begin
            if (lead_held_reg && in_byte[7:6] == 2'b10) begin
                if ({1'b0, held_count_reg} + 3'd1 < 3'(k_lead)) begin
                    cont_next[held_count_reg[0]] = in_byte;
                    held_count_next = held_count_reg + 2'd1;
                end else begin
                    lead_held_next  = 1'b0;
                    held_lead_next  = '0;
                    cont_next       = '0;
                    held_count_next = '0;
                    for (int i = 0; i < 3; i++) begin
                        if (i < int'(map_seq.n)) begin
                            job = add_char(job, map_seq.ch);
                        end
                    end
                end
            end else begin
                // broken sequence: lead and its continuations go out raw
                if (lead_held_reg) begin
                    job = add_char(job, held_lead_reg);
                    if (held_count_reg >= 2'd1) job = add_char(job, cont_reg[0]);
                    if (held_count_reg >= 2'd2) job = add_char(job, cont_reg[1]);
                    lead_held_next  = 1'b0;
                    held_lead_next  = '0;
                    cont_next       = '0;
                    held_count_next = '0;
                end
                take_lead = 1'b1;
            end
        end

        if (take_lead) begin
            case (k_byte)
                NEED_NONE: begin
                    if (map_byte.n != 2'd0) job = add_char(job, map_byte.ch);
                end
                NEED_RAW: begin
                    job = add_char(job, in_byte);
                end
                default: begin
                    held_lead_next  = in_byte;
                    lead_held_next  = 1'b1;
                    held_count_next = '0;
                end
            endcase
        end

        if (text_end) begin
            if (lead_held_next) begin
                job = add_char(job, held_lead_next);
                if (held_count_next >= 2'd1) job = add_char(job, cont_next[0]);
                if (held_count_next >= 2'd2) job = add_char(job, cont_next[1]);
            end
            lead_held_next  = 1'b0;
            held_lead_next  = '0;
            cont_next       = '0;
            held_count_next = '0;
        end
    end

    assign q_job  = job;
    assign q_push = accept && (job.n != '0 || text_end);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_held_reg  <= 1'b0;
            held_lead_reg  <= '0;
            cont_reg       <= '0;
            held_count_reg <= '0;
        end else if (accept) begin
            lead_held_reg  <= lead_held_next;
            held_lead_reg  <= held_lead_next;
            cont_reg       <= cont_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

// File: hdl/u2l_queue.sv
// Short job queue between the front end and the back end.
// Depends on u2l_pkg.
module u2l_queue #(
    parameter int unsigned DEPTH = u2l_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  u2l_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output u2l_pkg::job_t  head_job,
    output logic           head_valid
);
    import u2l_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    job_t            mem_reg [DEPTH];
    logic [PtrW-1:0] wptr_reg, wptr_next;
    logic [PtrW-1:0] rptr_reg, rptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PtrW'(DEPTH - 1)) ? '0 : wptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PtrW'(DEPTH - 1)) ? '0 : rptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CntW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/u2l_back.sv
// Back end: serialises queued jobs, applies the character limit, drives the result stream.
// Depends on u2l_pkg.
module u2l_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  u2l_pkg::job_t  head_job,
    input  logic           head_valid,
    output logic           pop,
    input  logic [15:0]    out_limit,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast
);
    import u2l_pkg::*;

    logic                  valid_reg, valid_next;
    logic [7:0]            char_reg, char_next;
    logic                  cv_reg, cv_next;
    logic                  rl_reg, rl_next;
    logic                  td_reg, td_next;
    logic [CHAR_IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]           emitted_reg, emitted_next;

    logic load;
    logic can_emit;
    logic last;

    assign load     = !valid_reg || m_tready;
    assign can_emit = ({1'b0, idx_reg} < head_job.n) && (emitted_reg < out_limit);
    assign last     = ({1'b0, idx_reg} + CHAR_CNT_W'(1) == head_job.n)
                      || (emitted_reg + 16'd1 == out_limit);

    always_comb begin
        valid_next   = valid_reg;
        char_next    = char_reg;
        cv_next      = cv_reg;
        rl_next      = rl_reg;
        td_next      = td_reg;
        idx_next     = idx_reg;
        emitted_next = emitted_reg;
        pop          = 1'b0;

        if (load) begin
            valid_next = 1'b0;
            if (head_valid) begin
                if (can_emit) begin
                    valid_next   = 1'b1;
                    char_next    = head_job.chars[idx_reg];
                    cv_next      = 1'b1;
                    rl_next      = last;
                    td_next      = last && head_job.text_end;
                    emitted_next = emitted_reg + 16'd1;
                    idx_next     = idx_reg + CHAR_IDX_W'(1);
                    if (last) begin
                        pop      = 1'b1;
                        idx_next = '0;
                        if (head_job.text_end) emitted_next = '0;
                    end
                end else begin
                    // nothing fits: only an end marker if the text ends here
                    pop      = 1'b1;
                    idx_next = '0;
                    char_next = 8'h00;
                    cv_next   = 1'b0;
                    rl_next   = 1'b1;
                    td_next   = 1'b1;
                    if (head_job.text_end) begin
                        valid_next   = 1'b1;
                        emitted_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            idx_reg     <= '0;
            emitted_reg <= '0;
        end else begin
            valid_reg   <= valid_next;
            idx_reg     <= idx_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        cv_reg   <= cv_next;
        rl_reg   <= rl_next;
        td_reg   <= td_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tuser  = {rl_reg, cv_reg};
    assign m_tlast  = td_reg;

endmodule

// File: hdl/utf8_to_latin1_transliterator.sv
// Path: a byte's job is written into the job queue, and the back end registers each result.
// Throughput: one byte per cycle while each byte yields at most one result and m_tready
// holds; a byte yielding more results holds the back end, and the job queue absorbs bursts.
// Reset: aresetn synchronous, active low; clears held bytes, queue, count and limit (511).
// Top level of the UTF-8 to Latin-1 transliterator; depends on u2l_pkg,
// u2l_front, u2l_queue and u2l_back.
module utf8_to_latin1_transliterator #(
    parameter int unsigned QUEUE_DEPTH = u2l_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic [1:0]  m_tuser,   // [0] char_valid, [1] run_last
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import u2l_pkg::*;

    logic [15:0] out_limit_reg, out_limit_next;
    logic        cfg_wr;

    job_t push_job;
    job_t head_job;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign out_limit_next = cfg_wr ? pwdata[15:0] : out_limit_reg;
    assign prdata = (paddr[2] == 1'b0) ? {16'b0, out_limit_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_limit_reg <= OUT_LIMIT_RST;
        end else begin
            out_limit_reg <= out_limit_next;
        end
    end

    u2l_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_byte  (s_tdata),
        .text_end (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_job    (push_job)
    );

    u2l_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    u2l_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (pop),
        .out_limit  (out_limit_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// File: hdl/u2l_checker.sv
// Port-level checker for the UTF-8 to Latin-1 transliterator, bound to the top level.
// Depends on utf8_to_latin1_transliterator_macros.svh.
`include "utf8_to_latin1_transliterator_macros.svh"

module u2l_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    `U2L_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result transaction dropped or changed while stalled")
    `U2L_ASSERT_NOW(a_marker_form, m_tvalid && !m_tuser[0], m_tdata == 8'h00 && m_tuser[1] && m_tlast, "end marker without zero char or run_last or text_done")
    `U2L_ASSERT_NOW(a_done_is_last, m_tvalid && m_tlast, m_tuser[1], "text_done without run_last")
    `U2L_ASSERT_NEXT(a_limit_readback, psel && penable && pwrite && pready && !paddr[2], !(psel && !pwrite && !paddr[2]) || (prdata[15:0] == $past(pwdata[15:0]) && prdata[31:16] == 16'h0000), "limit register reads back wrong value")

endmodule

bind utf8_to_latin1_transliterator u2l_checker u_checker (.*);

// File: sim/transliteration_checker.sv
// Checker for the UTF-8 to Latin-1 transliterator: watches the byte, character and APB channels.
// It predicts each character transaction and compares it with the oldest expectation.
// Standalone; the register address comes in as a parameter.
module transliteration_checker #(
    parameter logic [2:0] LIMIT_ADDR = 3'd0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,   // [7:0] out_char
    input  logic [1:0]        m_tuser,   // [0] char_valid, [1] run_last
    input  logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [15:0]       backlog,
    output int unsigned       mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BURST_MAX      = 4;
    localparam logic [15:0] LIMIT_AT_RESET = 16'd511;

    localparam logic [20:0] CP_NBSP        = 21'h0000A0;
    localparam logic [20:0] CP_SOFT_HYPHEN = 21'h0000AD;
    localparam logic [20:0] CP_LATIN1_TOP  = 21'h0000FF;
    localparam logic [20:0] CP_SQUOTE_LO   = 21'h002018;
    localparam logic [20:0] CP_SQUOTE_HI   = 21'h00201A;
    localparam logic [20:0] CP_DQUOTE_LO   = 21'h00201C;
    localparam logic [20:0] CP_DQUOTE_HI   = 21'h00201E;
    localparam logic [20:0] CP_EN_DASH     = 21'h002013;
    localparam logic [20:0] CP_EM_DASH     = 21'h002014;
    localparam logic [20:0] CP_ELLIPSIS    = 21'h002026;

    localparam logic [7:0] ASCII_SPACE  = 8'h20;
    localparam logic [7:0] ASCII_APOS   = 8'h27;
    localparam logic [7:0] ASCII_DQUOTE = 8'h22;
    localparam logic [7:0] ASCII_HYPHEN = 8'h2D;
    localparam logic [7:0] ASCII_DOT    = 8'h2E;
    localparam logic [7:0] ASCII_QMARK  = 8'h3F;

    // value = continuation bytes a lead asks for (RAW_BYTE: not a lead)
    typedef enum int unsigned {
        NEEDS_NONE  = 0,
        NEEDS_ONE   = 1,
        NEEDS_TWO   = 2,
        NEEDS_THREE = 3,
        RAW_BYTE    = 4
    } lead_class_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       run_last;
        logic       done;
    } latin1_out_t;

    latin1_out_t expected_chars [$];

    logic [7:0]  lead_byte;
    logic        lead_pending;
    logic [7:0]  tail_bytes [2];
    int unsigned tail_count;
    logic [15:0] char_limit;
    logic [15:0] chars_emitted;
    logic [7:0]  step_chars [BURST_MAX];
    int unsigned step_count;

    initial mismatches = 0;

    function automatic lead_class_t classify(logic [7:0] b);
        if (!b[7]) return NEEDS_NONE;
        if (b[7:5] == 3'b110) return NEEDS_ONE;
        if (b[7:4] == 4'b1110) return NEEDS_TWO;
        if (b[7:3] == 5'b11110) return NEEDS_THREE;
        return RAW_BYTE;
    endfunction

    task automatic report_mismatch(input string what, input latin1_out_t got,
                                   input latin1_out_t want);
        $display("%0t: %s: got char %02h valid %b run_last %b done %b, %s %02h %b %b %b",
                 $realtime, what, got.ch, got.valid, got.run_last, got.done,
                 "expected", want.ch, want.valid, want.run_last, want.done);
        mismatches++;
    endtask

    task automatic emit_char(input logic [7:0] c);
        if (chars_emitted < char_limit && step_count < BURST_MAX) begin
            step_chars[step_count] = c;
            step_count++;
            chars_emitted++;
        end
    endtask

    task automatic clear_held();
        lead_byte     = 8'd0;
        lead_pending  = 1'b0;
        tail_bytes[0] = 8'd0;
        tail_bytes[1] = 8'd0;
        tail_count    = 0;
    endtask

    task automatic map_code_point(input logic [20:0] cp);
        if (cp == CP_NBSP) begin
            emit_char(ASCII_SPACE);
        end else if (cp == CP_SOFT_HYPHEN) begin
        end else if (cp <= CP_LATIN1_TOP) begin
            emit_char(cp[7:0]);
        end else if (cp >= CP_SQUOTE_LO && cp <= CP_SQUOTE_HI) begin
            emit_char(ASCII_APOS);
        end else if (cp >= CP_DQUOTE_LO && cp <= CP_DQUOTE_HI) begin
            emit_char(ASCII_DQUOTE);
        end else if (cp == CP_EN_DASH || cp == CP_EM_DASH) begin
            emit_char(ASCII_HYPHEN);
        end else if (cp == CP_ELLIPSIS) begin
            repeat (3) emit_char(ASCII_DOT);
        end else begin
            emit_char(ASCII_QMARK);
        end
    endtask

    task automatic flush_held();
        int unsigned i;
        if (lead_pending) begin
            emit_char(lead_byte);
            for (i = 0; i < tail_count; i++) emit_char(tail_bytes[i]);
            clear_held();
        end
    endtask

    task automatic start_lead(input logic [7:0] b);
        lead_class_t k;
        k = classify(b);
        case (k)
            NEEDS_NONE: map_code_point({13'd0, b});
            RAW_BYTE:   emit_char(b);
            default: begin
                lead_byte    = b;
                lead_pending = 1'b1;
                tail_count   = 0;
            end
        endcase
    endtask

    task automatic add_continuation(input logic [7:0] b);
        lead_class_t k;
        logic [20:0] cp;
        k = classify(lead_byte);
        if (tail_count + 1 < int'(k) && tail_count < 2) begin
            tail_bytes[tail_count] = b;
            tail_count++;
        end else begin
            case (k)
                NEEDS_ONE: cp = {10'd0, lead_byte[4:0], b[5:0]};
                NEEDS_TWO: cp = {5'd0, lead_byte[3:0], tail_bytes[0][5:0], b[5:0]};
                default:   cp = {lead_byte[2:0], tail_bytes[0][5:0], tail_bytes[1][5:0], b[5:0]};
            endcase
            clear_held();
            map_code_point(cp);
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        int unsigned i;
        step_count = 0;
        if (b != 8'd0) begin
            if (lead_pending && b[7:6] == 2'b10) begin
                add_continuation(b);
            end else begin
                flush_held();
                start_lead(b);
            end
        end
        if (last) flush_held();
        for (i = 0; i < step_count; i++) begin
            expected_chars.push_back('{ch: step_chars[i], valid: 1'b1,
                                       run_last: (i + 1 == step_count),
                                       done: last && (i + 1 == step_count)});
        end
        if (last && step_count == 0) begin
            expected_chars.push_back('{ch: 8'd0, valid: 1'b0, run_last: 1'b1, done: 1'b1});
        end
        if (last) begin
            clear_held();
            chars_emitted = 16'd0;
        end
    endtask

    always @(posedge aclk) begin
        latin1_out_t got;
        latin1_out_t want;
        if (!aresetn) begin
            expected_chars.delete();
            clear_held();
            char_limit    = LIMIT_AT_RESET;
            chars_emitted = 16'd0;
            backlog      <= 16'd0;
        end else begin
            // results leave before this edge's byte can add any
            if (m_tvalid && m_tready) begin
                got = '{ch: m_tdata, valid: m_tuser[0], run_last: m_tuser[1], done: m_tlast};
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected transaction", got, '0);
                end else begin
                    want = expected_chars.pop_front();
                    if (got !== want) report_mismatch("transaction differs", got, want);
                end
            end
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) begin
                char_limit = pwdata[15:0];
            end
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
            backlog <= 16'(expected_chars.size());
        end
    end

endmodule

// File: sim/testbench.sv
// Top of the transliterator testbench: clock, reset, byte stimulus, APB limit writes, verdict.
// Depends on utf8_to_latin1_transliterator and transliteration_checker.
// Directed text first, then random phases of mostly well-formed UTF-8 under several limits.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  REG_OUT_LIMIT = 3'd0;
    localparam int unsigned QUIET_LIMIT   = 400;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned PHASE_BYTES   = 11;
    localparam int unsigned NUM_PHASES    = 7;
    localparam int unsigned RANDOM_PHASE  = 5;

    // {text_end, in_byte}
    localparam logic [8:0] DIRECTED_TEXT [23] = '{
        9'h041, 9'h07F,
        9'h0C2, 9'h0A0,
        9'h0C2, 9'h0AD,
        9'h0E2, 9'h080, 9'h098,
        9'h0E2, 9'h080, 9'h0A6,
        9'h0C0, 9'h080,
        9'h080, 9'h0FF,
        9'h0E2, 9'h080, 9'h041,
        9'h0F0, 9'h09F, 9'h198,
        9'h100
    };

    localparam logic [7:0] PUNCT_TAILS [10] = '{
        8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h93, 8'h94, 8'hA6
    };

    localparam logic [15:0] PHASE_LIMITS [NUM_PHASES] = '{
        16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd2, 16'd5, 16'd511
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] in_byte
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;           // [7:0] out_char
    logic [1:0]  m_tuser;           // [0] char_valid, [1] run_last
    logic        m_tlast;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] backlog;
    int unsigned mismatch_count;
    logic        idling_on    = 1'b1;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned bytes_sent   = 0;

    utf8_to_latin1_transliterator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    transliteration_checker #(
        .LIMIT_ADDR (REG_OUT_LIMIT)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .backlog    (backlog),
        .mismatches (mismatch_count)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (aresetn && idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= aresetn;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // waits for every predicted transaction; bytes still held in the block, with none yet, stay held
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (backlog != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_OUT_LIMIT;
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_fragment();
        logic [7:0] frag [$];
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: frag.push_back(8'($urandom_range(1, 127)));
            2: begin
                frag.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                frag.push_back(cont_byte());
            end
            3: begin
                frag.push_back(8'hE2);
                frag.push_back(8'h80);
                frag.push_back(PUNCT_TAILS[$urandom_range(0, 9)]);
            end
            4: begin
                frag.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                repeat (2) frag.push_back(cont_byte());
            end
            5: begin
                frag.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                repeat (3) frag.push_back(cont_byte());
            end
            6: begin
                frag.push_back(8'hC2);
                case ($urandom_range(0, 2))
                    0:       frag.push_back(8'hA0);
                    1:       frag.push_back(8'hAD);
                    default: frag.push_back(cont_byte());
                endcase
            end
            7: begin
                // truncated sequence, broken by whatever follows
                frag.push_back(8'($urandom_range(8'hE0, 8'hF7)));
                repeat ($urandom_range(0, 1)) frag.push_back(cont_byte());
            end
            8: frag.push_back(8'($urandom_range(1, 255)));
            default: begin
                if ($urandom_range(0, 1) == 0) frag.push_back(8'($urandom_range(8'h80, 8'hBF)));
                else frag.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            end
        endcase
        foreach (frag[i]) send_byte(frag[i], $urandom_range(0, 9) == 0);
    endtask

    initial begin
        int unsigned p;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_TEXT[i]) send_byte(DIRECTED_TEXT[i][7:0], DIRECTED_TEXT[i][8]);

        for (p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            if (p == RANDOM_PHASE) write_limit(16'($urandom_range(0, 8)));
            else write_limit(PHASE_LIMITS[p]);
            if (p == NUM_PHASES - 1) idling_on <= 1'b0;
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) begin
                if ($urandom_range(0, 29) == 0) drain_results();
                send_fragment();
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
